FILE: src/ilha_pkg.sv
// shared constants, types and defaults of the heap allocator
package ilha_pkg;

  // default heap size in 8-byte words
  localparam int unsigned HEAP_WORDS_DEFAULT = 64;

  // item field widths
  localparam int unsigned SIZE_W = 12;
  localparam int unsigned ADDR_W = 6;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // block geometry in bytes
  localparam int unsigned BLOCK_BYTES = 8;
  localparam int unsigned SPLIT_MIN   = 16;
  localparam int unsigned ALIGN_MASK  = 7;

  // result of one item
  typedef struct packed {
    logic              success;
    logic [ADDR_W-1:0] payload_address;
  } result_t;

endpackage

FILE: src/ilha_if.sv
// request and response channel interfaces of the heap allocator
interface ilha_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ilha_pkg::SIZE_W-1:0] alloc_size;
  logic [ilha_pkg::ADDR_W-1:0] block_address;

  modport source (output valid, action, alloc_size, block_address, input ready);
  modport sink   (input valid, action, alloc_size, block_address, output ready);
endinterface

interface ilha_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        success;
  logic [ilha_pkg::ADDR_W-1:0] payload_address;

  modport source (output valid, success, payload_address, input ready);
  modport sink   (input valid, success, payload_address, output ready);
endinterface

FILE: src/ilha_ram.sv
// generic single-write, single-read ram with registered read data
module ilha_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/ilha_walker.sv
// header walk sequencer: clearing pass, allocate walk with merge and split, free
module ilha_walker #(
  parameter int unsigned HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ilha_req_if.sink          in_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ilha_pkg::result_t res_o
);

  localparam int unsigned AW    = $clog2(HEAP_WORDS);
  localparam int unsigned HDR_W = $clog2(HEAP_WORDS * 8) + 1;
  localparam int unsigned NW    = AW + 2;
  localparam int unsigned CW    = (HDR_W > 14) ? HDR_W : 14;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HDR   = 8'b0000_0100,
    S_NEXT  = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_SPLIT = 8'b0010_0000,
    S_FREE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e                      state_q, state_d;
  logic [AW-1:0]               clr_q, clr_d;
  logic [AW-1:0]               cur_q, cur_d;
  logic [HDR_W-1:0]            hdr_q, hdr_d;
  logic                        nomerge_q, nomerge_d;
  logic [ilha_pkg::SIZE_W-1:0] req_q, req_d;
  logic [AW-1:0]               rest_addr_q, rest_addr_d;
  logic [HDR_W-1:0]            rest_val_q, rest_val_d;
  ilha_pkg::result_t           res_q, res_d;

  // ram port
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [HDR_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [HDR_W-1:0] ram_rdata;

  // datapath
  logic [HDR_W-1:0] hdr_cur;
  logic [HDR_W-1:0] sz;
  logic             cur_free;
  logic [NW-1:0]    next_w;
  logic             next_in;
  logic             cur_roomy;
  logic [CW-1:0]    req_c;
  logic [CW-1:0]    sz_c;
  logic [CW-1:0]    rounded_c;
  logic             fits;
  logic             split;
  logic [CW-1:0]    rest_w;
  logic [CW-1:0]    rest_c;
  logic [HDR_W-1:0] grant_hdr;
  logic [HDR_W-1:0] merged;
  logic [AW:0]      cur_p1;
  logic             free_bad;
  logic [AW-1:0]    free_idx;

  ilha_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HEAP_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // current header comes straight from the ram in S_HDR, else from the register
  assign hdr_cur   = (state_q == S_HDR) ? ram_rdata : hdr_q;
  assign sz        = {hdr_cur[HDR_W-1:1], 1'b0};
  assign cur_free  = ~hdr_cur[0];
  assign next_w    = NW'(cur_q) + NW'(hdr_cur[HDR_W-1:3]) + NW'(1);
  assign next_in   = next_w < NW'(HEAP_WORDS);
  assign cur_p1    = {1'b0, cur_q} + (AW+1)'(1);
  assign cur_roomy = NW'(cur_p1) < NW'(HEAP_WORDS);

  // fit test, rounding and split geometry
  assign req_c     = CW'(req_q);
  assign sz_c      = CW'(sz);
  assign rounded_c = (req_c + CW'(ilha_pkg::ALIGN_MASK)) & ~CW'(ilha_pkg::ALIGN_MASK);
  assign fits      = req_c <= sz_c;
  assign split     = sz_c >= (rounded_c + CW'(ilha_pkg::SPLIT_MIN));
  assign rest_w    = CW'(cur_q) + (rounded_c >> 3) + CW'(1);
  assign rest_c    = sz_c - (rounded_c + CW'(ilha_pkg::BLOCK_BYTES));
  assign grant_hdr = split ? HDR_W'(rounded_c + CW'(1)) : (hdr_cur | HDR_W'(1));

  // merge of the current free block with a free successor
  assign merged = hdr_q + ram_rdata + HDR_W'(ilha_pkg::BLOCK_BYTES);

  // free address checks
  assign free_bad = (in_i.block_address == '0) ||
                    (13'(in_i.block_address) > 13'(HEAP_WORDS));
  assign free_idx = AW'(in_i.block_address - ilha_pkg::ADDR_W'(1));

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cur_d       = cur_q;
    hdr_d       = hdr_q;
    nomerge_d   = nomerge_q;
    req_d       = req_q;
    rest_addr_d = rest_addr_q;
    rest_val_d  = rest_val_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = hdr_cur;
    ram_raddr   = cur_q;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == '0) ? HDR_W'((HEAP_WORDS - 1) * 8) : '0;
        if (clr_q == AW'(HEAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.action == ilha_pkg::ACT_ALLOC) begin
            req_d     = in_i.alloc_size;
            cur_d     = '0;
            nomerge_d = 1'b0;
            ram_raddr = '0;
            state_d   = S_HDR;
          end else if (free_bad) begin
            res_d   = '0;
            state_d = S_OUT;
          end else begin
            cur_d     = free_idx;
            ram_raddr = free_idx;
            state_d   = S_FREE;
          end
        end
      end
      S_HDR, S_EVAL: begin
        hdr_d = hdr_cur;
        if (cur_free && next_in && !nomerge_q) begin
          ram_raddr = next_w[AW-1:0];
          state_d   = S_NEXT;
        end else if (cur_free && fits && cur_roomy) begin
          ram_we                = 1'b1;
          ram_waddr             = cur_q;
          ram_wdata             = grant_hdr;
          res_d.success         = 1'b1;
          res_d.payload_address = ilha_pkg::ADDR_W'(cur_p1);
          rest_addr_d           = rest_w[AW-1:0];
          rest_val_d            = HDR_W'(rest_c);
          state_d               = split ? S_SPLIT : S_OUT;
        end else if (next_in) begin
          cur_d     = next_w[AW-1:0];
          ram_raddr = next_w[AW-1:0];
          nomerge_d = 1'b0;
          state_d   = S_HDR;
        end else begin
          res_d   = '0;
          state_d = S_OUT;
        end
      end
      S_NEXT: begin
        if (!ram_rdata[0]) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q;
          ram_wdata = merged;
          hdr_d     = merged;
          nomerge_d = 1'b0;
        end else begin
          nomerge_d = 1'b1;
        end
        state_d = S_EVAL;
      end
      S_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = rest_addr_q;
        ram_wdata = rest_val_q;
        state_d   = S_OUT;
      end
      S_FREE: begin
        res_d = '0;
        if (ram_rdata[0]) begin
          ram_we        = 1'b1;
          ram_waddr     = cur_q;
          ram_wdata     = {ram_rdata[HDR_W-1:1], 1'b0};
          res_d.success = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      nomerge_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      nomerge_q <= nomerge_d;
    end
  end

  // walk payload registers
  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    hdr_q       <= hdr_d;
    req_q       <= req_d;
    rest_addr_q <= rest_addr_d;
    rest_val_q  <= rest_val_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: src/implicit_list_heap_allocator_unit.sv
// First-fit heap allocator over an implicit list of inline block headers.
// Channels: in_i carries one item (action, alloc_size, block_address) per
// valid/ready handshake; out_o returns exactly one result (success,
// payload_address) per item, in order.
// After reset a clearing pass writes the header store (one free block
// spanning the heap in word 0, zeros elsewhere); in_i.ready stays low
// until it is done.
// One item is processed at a time. A free reads the header of its block
// and clears its busy flag if set, then offers its result; a free of
// address zero or beyond the heap offers its result without a read. An
// allocate reads each header it visits, probes the successor of a free
// block (merging it when free, else noting it busy), writes the rest
// header on a split and then offers its result. The header store is a
// single ram with one read and one write port and registered read data.
// Results go through an output register, so the next item is accepted while
// a result waits; when out_o stalls with a result still held and the next
// result is ready, the sequencer holds until out_o takes the first one.
module implicit_list_heap_allocator_unit #(
  parameter int unsigned HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilha_req_if.sink   in_i,
  ilha_rsp_if.source out_o
);

  logic              res_valid;
  logic              res_ready;
  ilha_pkg::result_t res;
  logic              out_valid_q;
  ilha_pkg::result_t out_q;

  ilha_walker #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register, refilled when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.success         = out_q.success;
  assign out_o.payload_address = out_q.payload_address;

endmodule

FILE: src/ilha_checker.sv
// port-level checker of the heap allocator and its bind
module ilha_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        out_success_i,
  input logic [ilha_pkg::ADDR_W-1:0] out_payload_address_i
);

  // a held result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_success_i) && $stable(out_payload_address_i))
    else $error("result payload changed while stalled");

  // failures carry address zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_success_i |-> out_payload_address_i == '0)
    else $error("failed result with nonzero address");

  // one item in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in work");

endmodule

bind implicit_list_heap_allocator_unit ilha_checker u_ilha_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_i.valid),
  .in_ready_i            (in_i.ready),
  .out_valid_i           (out_o.valid),
  .out_ready_i           (out_o.ready),
  .out_success_i         (out_o.success),
  .out_payload_address_i (out_o.payload_address)
);

FILE: test/implicit_list_heap_allocator_unit_checker.sv
// checker for the heap allocator: mirrors the header store and compares every result
`timescale 1ns / 100ps

module implicit_list_heap_allocator_unit_checker #(
  parameter int unsigned HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  ilha_req_if  req_i,
  ilha_rsp_if  rsp_i,
  output int   errors_o,
  output int   pending_o
);

  // header word: size in bytes plus busy flag in bit 0
  localparam int unsigned HDR_W = $clog2(HEAP_WORDS * ilha_pkg::BLOCK_BYTES) + 1;

  logic [HDR_W-1:0]  header_mirror [HEAP_WORDS];
  ilha_pkg::result_t pending_results [$];

  // one free block spanning the heap, zeros elsewhere
  initial begin
    for (int i = 0; i < HEAP_WORDS; i++) header_mirror[i] = '0;
    header_mirror[0] = HDR_W'(HEAP_WORDS * ilha_pkg::BLOCK_BYTES - ilha_pkg::BLOCK_BYTES);
  end

  // apply one item to the mirrored heap and return the result it must produce
  function automatic ilha_pkg::result_t apply_heap_item(
    logic act, logic [ilha_pkg::SIZE_W-1:0] req, logic [ilha_pkg::ADDR_W-1:0] addr);
    int unsigned       cur;
    int unsigned       nxt;
    int unsigned       hdr;
    int unsigned       sz;
    int unsigned       rounded;
    int unsigned       rest;
    bit                granted;
    ilha_pkg::result_t res;
    res = '0;
    if (act == ilha_pkg::ACT_FREE) begin
      // free: clear the busy flag of the word before the payload
      if (addr != 0 && addr <= HEAP_WORDS && header_mirror[addr - 1][0]) begin
        header_mirror[addr - 1][0] = 1'b0;
        res.success = 1'b1;
      end
      return res;
    end
    // allocate: first-fit walk with merging of free neighbors
    cur     = 0;
    granted = 1'b0;
    while (!granted && cur < HEAP_WORDS) begin
      hdr = header_mirror[cur];
      sz  = hdr & ~32'd1;
      nxt = cur + sz / ilha_pkg::BLOCK_BYTES + 1;
      if ((hdr & 1) == 0 && nxt < HEAP_WORDS && !header_mirror[nxt][0]) begin
        header_mirror[cur] = HDR_W'(hdr + header_mirror[nxt] + ilha_pkg::BLOCK_BYTES);
      end else if ((hdr & 1) == 0 && req <= sz && cur + 1 < HEAP_WORDS) begin
        rounded = (req + ilha_pkg::ALIGN_MASK) & ~ilha_pkg::ALIGN_MASK;
        if (sz >= rounded + ilha_pkg::SPLIT_MIN) begin
          rest = cur + rounded / ilha_pkg::BLOCK_BYTES + 1;
          header_mirror[rest] = HDR_W'(sz - (rounded + ilha_pkg::BLOCK_BYTES));
          header_mirror[cur]  = HDR_W'(rounded + 1);
        end else begin
          header_mirror[cur] = HDR_W'(hdr + 1);
        end
        res.success         = 1'b1;
        res.payload_address = ilha_pkg::ADDR_W'(cur + 1);
        granted             = 1'b1;
      end else begin
        cur = nxt;
      end
    end
    return res;
  endfunction

  // sample both channels mid-cycle, where handshake signals are stable
  always @(negedge clk_i) begin : watch
    ilha_pkg::result_t want;
    if (rst_ni) begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1)
        pending_results.push_back(apply_heap_item(req_i.action, req_i.alloc_size,
                                                  req_i.block_address));
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: success %0b payload_address %0d",
                 rsp_i.success, rsp_i.payload_address);
          errors_o++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.success !== want.success) begin
            $error("success: expected %0b, got %0b", want.success, rsp_i.success);
            errors_o++;
          end
          if (rsp_i.payload_address !== want.payload_address) begin
            $error("payload_address: expected %0d, got %0d",
                   want.payload_address, rsp_i.payload_address);
            errors_o++;
          end
        end
      end
    end
    pending_o = pending_results.size();
  end

endmodule

FILE: test/implicit_list_heap_allocator_unit_tb.sv
// top of the heap allocator testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module implicit_list_heap_allocator_unit_tb;

  localparam int unsigned HEAP_WORDS = ilha_pkg::HEAP_WORDS_DEFAULT;
  localparam int unsigned TAIL_CYCLES = 3 * HEAP_WORDS + 16;

  logic clk_i;
  logic rst_ni;
  int   chk_errors;
  int   chk_pending;

  // idle percentages of sender and receiver, and the current idling phase
  int snd_idle   = 7;
  int rcv_idle   = 70;
  int idle_phase = 0;

  // payload addresses granted so far, used to aim frees at live blocks
  logic [ilha_pkg::ADDR_W-1:0] granted_addrs [$];

  ilha_req_if req_if ();
  ilha_rsp_if rsp_if ();

  implicit_list_heap_allocator_unit #(
    .HEAP_WORDS(HEAP_WORDS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  implicit_list_heap_allocator_unit_checker #(
    .HEAP_WORDS(HEAP_WORDS)
  ) heap_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_if),
    .rsp_i    (rsp_if),
    .errors_o (chk_errors),
    .pending_o(chk_pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("implicit_list_heap_allocator_unit_tb: errors");
    $finish;
  end

  // receiver ready, with one long hold-off at the start of the last phase
  initial begin : rsp_ready_drive
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_phase == 2 && !held) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // collect granted addresses from accepted results
  always @(negedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1 &&
        rsp_if.success === 1'b1 && rsp_if.payload_address != 0)
      granted_addrs.push_back(rsp_if.payload_address);
  end

  // offer one item and wait until it is taken; called and returns at a rising edge
  task automatic issue_item(logic act, logic [ilha_pkg::SIZE_W-1:0] sz,
                            logic [ilha_pkg::ADDR_W-1:0] addr);
    bit taken;
    if ($urandom_range(99) < snd_idle) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    req_if.valid         <= 1'b1;
    req_if.action        <= act;
    req_if.alloc_size    <= sz;
    req_if.block_address <= addr;
    do begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // random item: mostly allocations and frees of live blocks, some stray frees
  task automatic random_item();
    int pick;
    int sel;
    int idx;
    logic [ilha_pkg::SIZE_W-1:0] sz;
    logic [ilha_pkg::ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    addr = ilha_pkg::ADDR_W'($urandom_range(63));
    sz   = ilha_pkg::SIZE_W'($urandom_range(4095));
    if (pick < 50) begin
      sel = $urandom_range(99);
      if (sel < 60)      sz = ilha_pkg::SIZE_W'($urandom_range(64));
      else if (sel < 85) sz = ilha_pkg::SIZE_W'($urandom_range(255));
      else if (sel < 95)
        sz = ilha_pkg::SIZE_W'($urandom_range(HEAP_WORDS * ilha_pkg::BLOCK_BYTES - 8));
      issue_item(ilha_pkg::ACT_ALLOC, sz, addr);
    end else if (pick < 90 && granted_addrs.size() != 0) begin
      idx  = $urandom_range(granted_addrs.size() - 1);
      addr = granted_addrs[idx];
      granted_addrs.delete(idx);
      issue_item(ilha_pkg::ACT_FREE, sz, addr);
    end else begin
      issue_item(ilha_pkg::ACT_FREE, sz, addr);
    end
  endtask

  // reset, stimulus and verdict
  initial begin
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.action        = ilha_pkg::ACT_ALLOC;
    req_if.alloc_size    = '0;
    req_if.block_address = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero-byte grant, oversize miss, free of zero, double free
    issue_item(ilha_pkg::ACT_ALLOC, 12'd0, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd4095, 6'd63);
    issue_item(ilha_pkg::ACT_FREE, 12'd4095, 6'd0);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd1);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd1);
    // whole heap after merging, then a full heap
    issue_item(ilha_pkg::ACT_ALLOC, 12'd504, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd8, 6'd0);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd1);
    // carve up the tail of the heap down to its last words
    issue_item(ilha_pkg::ACT_ALLOC, 12'd480, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd0, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd1, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd0, 6'd0);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd63);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd62);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd9, 6'd0);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd1);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd62);
    // no fit after merging everything, then an exact fit with rounding
    issue_item(ilha_pkg::ACT_ALLOC, 12'd4095, 6'd0);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd503, 6'd0);
    // stray free, then release and a small request
    issue_item(ilha_pkg::ACT_FREE, 12'd4095, 6'd33);
    issue_item(ilha_pkg::ACT_FREE, 12'd0, 6'd1);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd7, 6'd63);
    issue_item(ilha_pkg::ACT_ALLOC, 12'd16, 6'd42);
    issue_item(ilha_pkg::ACT_FREE, 12'd2730, 6'd63);

    // random phases with different idling of both sides
    repeat (235) random_item();
    snd_idle   = 70;
    rcv_idle   = 7;
    idle_phase = 1;
    repeat (235) random_item();
    snd_idle   = 0;
    rcv_idle   = 0;
    idle_phase = 2;
    repeat (235) random_item();
    req_if.valid <= 1'b0;

    // drain outstanding results, then let the block settle
    while (chk_pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (chk_errors == 0) begin
      $display("implicit_list_heap_allocator_unit_tb: clean");
    end else begin
      $display("implicit_list_heap_allocator_unit_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/ilha_pkg.sv
src/ilha_if.sv
src/ilha_ram.sv
src/ilha_walker.sv
src/implicit_list_heap_allocator_unit.sv
src/ilha_checker.sv
test/implicit_list_heap_allocator_unit_checker.sv
test/implicit_list_heap_allocator_unit_tb.sv
